@@ rtl/cleb_pkg.sv @@
// Shared types and constants for the console line edit buffer.
// Holds the word structs of both channels, key codes and the echo kind codes.
// No dependencies.
package cleb_pkg;

  localparam int CLEB_DEPTH = 128;

  localparam logic MODE_KEY  = 1'b0;
  localparam logic MODE_READ = 1'b1;

  localparam logic [7:0] KEY_NUL    = 8'h00;
  localparam logic [7:0] KEY_CTRL_D = 8'h04;
  localparam logic [7:0] KEY_CTRL_H = 8'h08;
  localparam logic [7:0] KEY_NL     = 8'h0A;
  localparam logic [7:0] KEY_CR     = 8'h0D;
  localparam logic [7:0] KEY_CTRL_U = 8'h15;
  localparam logic [7:0] KEY_CTRL_X = 8'h18;
  localparam logic [7:0] KEY_DEL    = 8'h7F;

  typedef enum logic [1:0] {
    ECHO_NONE  = 2'd0,
    ECHO_CHAR  = 2'd1,
    ECHO_ERASE = 2'd2
  } echo_kind_t;

  typedef struct packed {
    logic       mode;
    logic [7:0] key;
    logic       read_first;
  } cleb_in_t;

  typedef struct packed {
    echo_kind_t echo_kind;
    logic [7:0] echo_char;
    logic [7:0] erase_count;
    logic       wake;
    logic       read_valid;
    logic [7:0] read_char;
    logic       read_end;
    logic       read_empty;
  } cleb_out_t;

endpackage

@@ rtl/cleb_ram.sv @@
// Generic single-port-write, single-port-read RAM with a registered read.
// Used for the line store of the console line edit buffer. No dependencies.
module cleb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

@@ rtl/console_line_edit_buffer_unit.sv @@
// Cooked-mode console input buffer: a ring of DEPTH characters with read,
// committed and edit pointers. Depends on cleb_pkg and cleb_ram.
//
// Usage: one input channel (in_valid, in_stall, in_word) carries either a
// key received from the UART or a request for one character from a reader.
// Every accepted word produces exactly one result word on the output channel
// (out_valid, out_stall, out_word), in order.
// A word accepted at a clock edge sits in the input register, is handled
// there and its result is written into the output register, from which
// out_valid and out_word are driven.
// Throughput is one word per clock cycle while the receiver does not stall;
// the pointer update is combinational, and the character at the read pointer
// is read early from the line store's registered port, so reads never wait.
// While the receiver stalls, the result is held and the input register
// fills; in_stall then rises until the result is taken.
// Synchronous active-low reset empties the ring (all three pointers to zero)
// and drops any words in flight; the line store itself is not cleared.
module console_line_edit_buffer_unit #(
  parameter int DEPTH = cleb_pkg::CLEB_DEPTH
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  cleb_pkg::cleb_in_t  in_word,
  output logic               out_valid,
  input  logic               out_stall,
  output cleb_pkg::cleb_out_t out_word
);

  import cleb_pkg::*;

  localparam int PTR_W = $clog2(2 * DEPTH);
  localparam int IDX_W = $clog2(DEPTH);
  localparam logic [PTR_W-1:0] PTR_MAX   = PTR_W'(2 * DEPTH - 1);
  localparam logic [PTR_W-1:0] PTR_DEPTH = PTR_W'(DEPTH);
  localparam logic [PTR_W-1:0] LAST_FREE = PTR_W'(DEPTH - 1);

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_MAX) ? '0 : p + PTR_W'(1);
  endfunction

  function automatic logic [PTR_W-1:0] ptr_dec(input logic [PTR_W-1:0] p);
    return (p == '0) ? PTR_MAX : p - PTR_W'(1);
  endfunction

  function automatic logic [PTR_W-1:0] ring_dist(input logic [PTR_W-1:0] a,
                                                 input logic [PTR_W-1:0] b);
    return (a >= b) ? a - b : a + (PTR_MAX - b) + PTR_W'(1);
  endfunction

  function automatic logic [IDX_W-1:0] ptr_idx(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] q;
    q = (p >= PTR_DEPTH) ? p - PTR_DEPTH : p;
    return q[IDX_W-1:0];
  endfunction

  logic             in_vld_r;
  cleb_in_t         in_word_r;
  logic             out_vld_r;
  cleb_out_t        out_word_r;
  logic [PTR_W-1:0] read_ptr_r, read_ptr_nxt;
  logic [PTR_W-1:0] commit_ptr_r, commit_ptr_nxt;
  logic [PTR_W-1:0] edit_ptr_r, edit_ptr_nxt;
  logic             byp_r;
  logic [7:0]       byp_data_r;

  logic             advance;
  logic             work;
  cleb_out_t        res;
  logic             wr_en;
  logic [7:0]       wr_data;
  logic [IDX_W-1:0] wr_idx;
  logic [IDX_W-1:0] rd_idx;
  logic [7:0]       rd_data;
  logic [7:0]       head_char;
  logic [PTR_W-1:0] dist_ec;
  logic [PTR_W-1:0] dist_er;
  logic [7:0]       ch;

  assign advance   = !out_vld_r || !out_stall;
  assign work      = in_vld_r && advance;
  assign in_stall  = in_vld_r && !advance;
  assign out_valid = out_vld_r;
  assign out_word  = out_word_r;

  assign head_char = byp_r ? byp_data_r : rd_data;
  assign dist_ec   = ring_dist(edit_ptr_r, commit_ptr_r);
  assign dist_er   = ring_dist(edit_ptr_r, read_ptr_r);
  assign wr_idx    = ptr_idx(edit_ptr_r);
  assign rd_idx    = ptr_idx(read_ptr_nxt);
  assign ch        = (in_word_r.key == KEY_CR || in_word_r.key == KEY_CTRL_D) ?
                     KEY_NL : in_word_r.key;

  always_comb begin
    res            = '0;
    wr_en          = 1'b0;
    wr_data        = ch;
    read_ptr_nxt   = read_ptr_r;
    commit_ptr_nxt = commit_ptr_r;
    edit_ptr_nxt   = edit_ptr_r;
    if (work) begin
      if (in_word_r.mode == MODE_KEY) begin
        unique case (in_word_r.key) inside
          KEY_NUL, KEY_CTRL_X: begin
          end
          KEY_CTRL_U: begin
            edit_ptr_nxt = commit_ptr_r;
            if (dist_ec != '0) begin
              res.echo_kind   = ECHO_ERASE;
              res.erase_count = ({8'd0, dist_ec} > (PTR_W + 8)'(255)) ?
                                8'hFF : 8'(dist_ec);
            end
          end
          KEY_CTRL_H, KEY_DEL: begin
            if (edit_ptr_r != commit_ptr_r) begin
              edit_ptr_nxt    = ptr_dec(edit_ptr_r);
              res.echo_kind   = ECHO_ERASE;
              res.erase_count = 8'd1;
            end
          end
          default: begin
            if (dist_er < PTR_DEPTH) begin
              res.echo_kind = ECHO_CHAR;
              res.echo_char = ch;
              wr_en         = 1'b1;
              edit_ptr_nxt  = ptr_inc(edit_ptr_r);
              if (ch == KEY_NL || dist_er == LAST_FREE) begin
                commit_ptr_nxt = ptr_inc(edit_ptr_r);
                res.wake       = 1'b1;
              end
            end
          end
        endcase
      end else begin
        if (read_ptr_r == commit_ptr_r) begin
          res.read_empty = 1'b1;
        end else if (head_char == KEY_NL) begin
          res.read_end = 1'b1;
          if (in_word_r.read_first) begin
            read_ptr_nxt = ptr_inc(read_ptr_r);
          end
        end else begin
          res.read_valid = 1'b1;
          res.read_char  = head_char;
          read_ptr_nxt   = ptr_inc(read_ptr_r);
        end
      end
    end
  end

  cleb_ram #(
    .WIDTH (8),
    .DEPTH (DEPTH)
  ) u_line_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_idx),
    .wr_data (wr_data),
    .rd_addr (rd_idx),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r     <= 1'b0;
      out_vld_r    <= 1'b0;
      read_ptr_r   <= '0;
      commit_ptr_r <= '0;
      edit_ptr_r   <= '0;
      byp_r        <= 1'b0;
    end else begin
      if (!in_vld_r || advance) begin
        in_vld_r <= in_valid;
      end
      if (advance) begin
        out_vld_r <= in_vld_r;
      end
      read_ptr_r   <= read_ptr_nxt;
      commit_ptr_r <= commit_ptr_nxt;
      edit_ptr_r   <= edit_ptr_nxt;
      byp_r        <= wr_en && (wr_idx == rd_idx);
    end
  end

  always_ff @(posedge clk) begin
    if (!in_vld_r || advance) begin
      in_word_r <= in_word;
    end
    if (work) begin
      out_word_r <= res;
    end
    byp_data_r <= wr_data;
  end

endmodule
